// File: hdl/dmpid_pkg.sv
`default_nettype none

package dmpid_pkg;

   // Fixed block dimensions
   localparam int MOTORS       = 2;
   localparam int DUTY_LIMIT   = 10000;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 56;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int DIV_STEPS    = 15;

   // Feed-forward constants
   localparam int FF_KNEE      = 1000;
   localparam int FF_DIVISOR   = 65;
   localparam int FF_SLOPE     = 10;
   // s*1000/65 = s*200/13; (|s| * FF_RECIP) >> FF_RECIP_SHIFT is exact for |s| <= 2048
   localparam int FF_RECIP       = 1008247;
   localparam int FF_RECIP_SHIFT = 16;

   // Register reset values
   localparam logic [15:0] PROP_RESET  = 16'd4608;
   localparam logic [15:0] INTEG_RESET = 16'd2304;
   localparam logic [15:0] DERIV_RESET = 16'd0;
   localparam logic [15:0] VREF_RESET  = 16'd12600;

   typedef enum logic [1:0] {
      CSR_PROP  = 2'd0,
      CSR_INTEG = 2'd1,
      CSR_DERIV = 2'd2,
      CSR_VREF  = 2'd3
   } csr_index_type;

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_LOAD   = 15'b000000000000010,
      ST_MUL_P  = 15'b000000000000100,
      ST_MUL_I  = 15'b000000000001000,
      ST_MUL_D  = 15'b000000000010000,
      ST_CORR   = 15'b000000000100000,
      ST_ACCUM  = 15'b000000001000000,
      ST_FFWD   = 15'b000000010000000,
      ST_DIV    = 15'b000000100000000,
      ST_FF_END = 15'b000001000000000,
      ST_TOTAL  = 15'b000010000000000,
      ST_SCALE  = 15'b000100000000000,
      ST_CHECK  = 15'b001000000000000,
      ST_DUTY   = 15'b010000000000000,
      ST_OUT    = 15'b100000000000000
   } seq_state_type;

endpackage

`default_nettype wire

// File: hdl/dual_motor_incremental_pid_drive_core.sv
`default_nettype none

// Dual-motor incremental PID velocity loop. Each request carries the left and
// right target speeds, the encoder counts of this tick, a run flag and the
// battery voltage; each response carries forward and reverse PWM duties for
// both wheels. Per motor the block forms the speed error, runs an incremental
// PID (gains are unsigned Q8.8) into an accumulator held within +/-10000,
// adds a piecewise-linear feed-forward of the target, scales the sum by
// reference_voltage/supply_mv and limits the duty to +/-10000. All math runs
// through one multiplier and one 15-step restoring divider under a small
// sequencer, one motor after the other, and the block takes no new request
// until the response has been taken. Per motor the sequencer does the PID
// work (load, three multiplies, correction, accumulate), then the
// feed-forward, total, scaling, check and duty selection, with one more
// state to restore the feed-forward sign when the target is below 1000 (the
// divide by 65 is a reciprocal multiply), and one divider pass for the
// compensation (skipped when the scaled sum is zero or the duty clearly
// saturates); the response and idle states close each request. A zero
// supply drives the duty to the limit in the sign of the sum. Gains and
// reference voltage sit on the APB port at byte addresses 0x0, 0x4, 0x8
// and 0xC; write them only while the block is idle.

module dual_motor_incremental_pid_drive_core (
   input  wire  logic                               clock,
   input  wire  logic                               reset,
   // target_left[11:0], target_right[23:12], count_left[35:24],
   // count_right[47:36], supply_mv[61:48], zero pad [63:62]
   input  wire  logic [dmpid_pkg::REQ_DATA_W-1:0]   req_tdata,
   // run_enable
   input  wire  logic                               req_tuser,
   input  wire  logic                               req_tvalid,
   output       logic                               req_tready,
   // fwd_left[13:0], rev_left[27:14], fwd_right[41:28], rev_right[55:42]
   output       logic [dmpid_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output       logic                               rsp_tvalid,
   input  wire  logic                               rsp_tready,
   input  wire  logic                               csr_psel,
   input  wire  logic                               csr_penable,
   input  wire  logic                               csr_pwrite,
   input  wire  logic [dmpid_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire  logic [dmpid_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output       logic [dmpid_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output       logic                               csr_pready
);
   import dmpid_pkg::*;

   localparam logic signed [16:0] ACC_HI  = 17'(DUTY_LIMIT);
   localparam logic signed [16:0] ACC_LO  = -17'(DUTY_LIMIT);
   localparam logic [14:0]        DUTY_MX = 15'(DUTY_LIMIT);

   // Sequencer
   seq_state_type state_ff, state_in;
   logic          motor_ff, motor_in;
   logic [3:0]    step_ff, step_in;
   logic          neg_ff, neg_in;

   // Configuration
   logic [15:0] prop_ff, prop_in;
   logic [15:0] integ_ff, integ_in;
   logic [15:0] deriv_ff, deriv_in;
   logic [15:0] vref_ff, vref_in;

   // Captured request
   logic signed [11:0] tgt_ff [MOTORS];
   logic signed [11:0] tgt_in [MOTORS];
   logic signed [11:0] cnt_ff [MOTORS];
   logic signed [11:0] cnt_in [MOTORS];
   logic [13:0]        supply_ff, supply_in;

   // Loop state per motor
   logic signed [12:0] prev_err_ff  [MOTORS];
   logic signed [12:0] prev_err_in  [MOTORS];
   logic signed [12:0] older_err_ff [MOTORS];
   logic signed [12:0] older_err_in [MOTORS];
   logic signed [15:0] accum_ff     [MOTORS];
   logic signed [15:0] accum_in     [MOTORS];

   // Working registers
   logic signed [12:0] err_ff, err_in;
   logic signed [13:0] diff1_ff, diff1_in;
   logic signed [15:0] diff2_ff, diff2_in;
   logic signed [35:0] work_ff, work_in;     // product sum, dividend, remainder
   logic signed [15:0] corr_ff, corr_in;
   logic signed [15:0] ffwd_ff, ffwd_in;
   logic signed [17:0] total_ff, total_in;
   logic [29:0]        dsr_ff, dsr_in;
   logic [14:0]        quot_ff, quot_in;

   // Result holding registers
   logic [13:0] fwd_out_ff [MOTORS];
   logic [13:0] fwd_out_in [MOTORS];
   logic [13:0] rev_out_ff [MOTORS];
   logic [13:0] rev_out_in [MOTORS];

   // Shared multiplier
   logic signed [17:0] mul_a;
   logic [19:0]        mul_b;
   logic signed [38:0] product;

   // Helpers
   logic signed [11:0] setp;
   logic signed [12:0] setp_ext, setp_mag;
   logic signed [35:0] corr_sum, corr_shr;
   logic signed [16:0] acc_sum;
   logic signed [17:0] total_mag;
   logic signed [15:0] quot_s;
   logic [14:0]        duty_mag;
   logic               div_ge;
   logic               csr_wr;
   logic               req_acc;
   csr_index_type      csr_idx;

   assign setp     = tgt_ff[motor_ff];
   assign setp_ext = 13'(setp);
   assign setp_mag = setp_ext[12] ? -setp_ext : setp_ext;
   assign total_mag = total_ff[17] ? -total_ff : total_ff;
   // feed-forward magnitude: reciprocal product scaled back down
   assign quot_s   = 16'(work_ff >>> FF_RECIP_SHIFT);
   assign duty_mag = (quot_ff > DUTY_MX) ? DUTY_MX : quot_ff;
   assign div_ge   = work_ff[31:0] >= {2'b00, dsr_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tdata  = {rev_out_ff[1], fwd_out_ff[1], rev_out_ff[0], fwd_out_ff[0]};

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   // Return the addressed register
   always_comb begin
      unique case (csr_idx)
         CSR_PROP:  csr_prdata = {16'd0, prop_ff};
         CSR_INTEG: csr_prdata = {16'd0, integ_ff};
         CSR_DERIV: csr_prdata = {16'd0, deriv_ff};
         CSR_VREF:  csr_prdata = {16'd0, vref_ff};
      endcase
   end

   // Steer the multiplier operands by sequencer step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_P: begin
            mul_a = 18'(diff1_ff);
            mul_b = 20'(prop_ff);
         end
         ST_MUL_I: begin
            mul_a = 18'(err_ff);
            mul_b = 20'(integ_ff);
         end
         ST_MUL_D: begin
            mul_a = 18'(diff2_ff);
            mul_b = 20'(deriv_ff);
         end
         ST_FFWD: begin
            if (setp < 12'(FF_KNEE)) begin
               mul_a = 18'(setp_mag);
               mul_b = 20'(FF_RECIP);
            end else begin
               mul_a = 18'(setp) - 18'(FF_DIVISOR);
               mul_b = 20'(FF_SLOPE);
            end
         end
         ST_SCALE: begin
            mul_a = total_mag;
            mul_b = 20'(vref_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * $signed({1'b0, mul_b});

   // Correction: divide by 256 toward zero
   assign corr_sum = work_ff + (work_ff[35] ? 36'sd255 : 36'sd0);
   assign corr_shr = corr_sum >>> 8;
   assign acc_sum  = 17'(accum_ff[motor_ff]) + 17'(corr_ff);

   always_comb begin
      state_in     = state_ff;
      motor_in     = motor_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      prop_in      = prop_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      vref_in      = vref_ff;
      tgt_in       = tgt_ff;
      cnt_in       = cnt_ff;
      supply_in    = supply_ff;
      prev_err_in  = prev_err_ff;
      older_err_in = older_err_ff;
      accum_in     = accum_ff;
      err_in       = err_ff;
      diff1_in     = diff1_ff;
      diff2_in     = diff2_ff;
      work_in      = work_ff;
      corr_in      = corr_ff;
      ffwd_in      = ffwd_ff;
      total_in     = total_ff;
      dsr_in       = dsr_ff;
      quot_in      = quot_ff;
      fwd_out_in   = fwd_out_ff;
      rev_out_in   = rev_out_ff;

      if (csr_wr) begin
         unique case (csr_idx)
            CSR_PROP:  prop_in  = csr_pwdata[15:0];
            CSR_INTEG: integ_in = csr_pwdata[15:0];
            CSR_DERIV: deriv_in = csr_pwdata[15:0];
            CSR_VREF:  vref_in  = csr_pwdata[15:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               // a cleared run flag zeroes both targets
               tgt_in[0] = req_tuser ? $signed(req_tdata[11:0])  : 12'sd0;
               tgt_in[1] = req_tuser ? $signed(req_tdata[23:12]) : 12'sd0;
               cnt_in[0] = $signed(req_tdata[35:24]);
               cnt_in[1] = $signed(req_tdata[47:36]);
               supply_in = req_tdata[61:48];
               motor_in  = 1'b0;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            err_in   = 13'(setp) - 13'(cnt_ff[motor_ff]);
            diff1_in = 14'(13'(setp) - 13'(cnt_ff[motor_ff]))
                       - 14'(prev_err_ff[motor_ff]);
            diff2_in = 16'(13'(setp) - 13'(cnt_ff[motor_ff]))
                       - 16'(prev_err_ff[motor_ff]) - 16'(prev_err_ff[motor_ff])
                       + 16'(older_err_ff[motor_ff]);
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            work_in  = 36'(product);
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            work_in  = work_ff + 36'(product);
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            work_in  = work_ff + 36'(product);
            state_in = ST_CORR;
         end
         ST_CORR: begin
            if (corr_shr > 36'sd32767) begin
               corr_in = 16'sh7fff;
            end else if (corr_shr < -36'sd32768) begin
               corr_in = 16'sh8000;
            end else begin
               corr_in = corr_shr[15:0];
            end
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (acc_sum > ACC_HI) begin
               accum_in[motor_ff] = ACC_HI[15:0];
            end else if (acc_sum < ACC_LO) begin
               accum_in[motor_ff] = ACC_LO[15:0];
            end else begin
               accum_in[motor_ff] = acc_sum[15:0];
            end
            older_err_in[motor_ff] = prev_err_ff[motor_ff];
            prev_err_in[motor_ff]  = err_ff;
            state_in = ST_FFWD;
         end
         ST_FFWD: begin
            if (setp < 12'(FF_KNEE)) begin
               // |s|*1000/65 by reciprocal multiply, sign restored afterwards
               work_in  = 36'(product);
               neg_in   = setp[11];
               state_in = ST_FF_END;
            end else begin
               ffwd_in  = 16'(product + 39'(FF_KNEE));
               state_in = ST_TOTAL;
            end
         end
         ST_DIV: begin
            // one restoring step per cycle
            if (div_ge) begin
               work_in = work_ff - $signed({6'd0, dsr_ff});
               quot_in = {quot_ff[13:0], 1'b1};
            end else begin
               quot_in = {quot_ff[13:0], 1'b0};
            end
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(DIV_STEPS - 1)) begin
               state_in = ST_DUTY;
            end
         end
         ST_FF_END: begin
            ffwd_in  = neg_ff ? -quot_s : quot_s;
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            total_in = 18'(ffwd_ff) + 18'(accum_ff[motor_ff]);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            work_in  = 36'(product);
            neg_in   = total_ff[17];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // zero scaled sum gives zero duty, except that a zero supply
            // saturates any nonzero sum; a quotient past 15 bits saturates,
            // which also covers a zero supply
            priority if (work_ff == 36'sd0 &&
                         (supply_ff != 14'd0 || total_ff == 18'sd0)) begin
               quot_in  = '0;
               state_in = ST_DUTY;
            end else if (work_ff[31:0] >= {3'd0, supply_ff, 15'd0}) begin
               quot_in  = '1;
               state_in = ST_DUTY;
            end else begin
               dsr_in      = 30'(supply_ff) << (DIV_STEPS - 1);
               step_in     = '0;
               state_in    = ST_DIV;
            end
         end
         ST_DUTY: begin
            if (neg_ff) begin
               fwd_out_in[motor_ff] = '0;
               rev_out_in[motor_ff] = duty_mag[13:0];
            end else begin
               fwd_out_in[motor_ff] = duty_mag[13:0];
               rev_out_in[motor_ff] = '0;
            end
            if (motor_ff == 1'(MOTORS - 1)) begin
               state_in = ST_OUT;
            end else begin
               motor_in = motor_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prop_ff      <= PROP_RESET;
         integ_ff     <= INTEG_RESET;
         deriv_ff     <= DERIV_RESET;
         vref_ff      <= VREF_RESET;
         for (int m = 0; m < MOTORS; m++) begin
            prev_err_ff[m]  <= '0;
            older_err_ff[m] <= '0;
            accum_ff[m]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         prop_ff      <= prop_in;
         integ_ff     <= integ_in;
         deriv_ff     <= deriv_in;
         vref_ff      <= vref_in;
         prev_err_ff  <= prev_err_in;
         older_err_ff <= older_err_in;
         accum_ff     <= accum_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      motor_ff    <= motor_in;
      step_ff     <= step_in;
      neg_ff      <= neg_in;
      tgt_ff      <= tgt_in;
      cnt_ff      <= cnt_in;
      supply_ff   <= supply_in;
      err_ff      <= err_in;
      diff1_ff    <= diff1_in;
      diff2_ff    <= diff2_in;
      work_ff     <= work_in;
      corr_ff     <= corr_in;
      ffwd_ff     <= ffwd_in;
      total_ff    <= total_in;
      dsr_ff      <= dsr_in;
      quot_ff     <= quot_in;
      fwd_out_ff  <= fwd_out_in;
      rev_out_ff  <= rev_out_in;
   end

endmodule

`default_nettype wire

// File: hdl/dmpid_checker.sv
`default_nettype none

module dmpid_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [dmpid_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready
);
   import dmpid_pkg::*;

   // Response register is empty right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // One request in flight: never ready while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready while response pending");

   // Busy after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after a request");

   // Duties stay in range and only one direction drives
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[13:0] == 14'd0 || rsp_tdata[27:14] == 14'd0) &&
         (rsp_tdata[41:28] == 14'd0 || rsp_tdata[55:42] == 14'd0) &&
         rsp_tdata[13:0] <= 14'(DUTY_LIMIT) && rsp_tdata[27:14] <= 14'(DUTY_LIMIT) &&
         rsp_tdata[41:28] <= 14'(DUTY_LIMIT) && rsp_tdata[55:42] <= 14'(DUTY_LIMIT))
      else $error("duty out of range");

endmodule

bind dual_motor_incremental_pid_drive_core dmpid_checker u_dmpid_checker (.*);

`default_nettype wire

// File: tb/drive_duty_checker.sv
`timescale 1ns / 1ps

module drive_duty_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // target_left[11:0], target_right[23:12], count_left[35:24],
   // count_right[47:36], supply_mv[61:48], zero pad [63:62]
   input  wire logic [dmpid_pkg::REQ_DATA_W-1:0]   req_tdata,
   // run_enable
   input  wire logic                               req_tuser,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   // fwd_left[13:0], rev_left[27:14], fwd_right[41:28], rev_right[55:42]
   input  wire logic [dmpid_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [dmpid_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [dmpid_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  wire logic [dmpid_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  wire logic                               csr_pready,
   output int                                      mismatch_count,
   output int                                      outstanding
);
   import dmpid_pkg::*;

   typedef struct packed {
      logic [13:0] rev_right;
      logic [13:0] fwd_right;
      logic [13:0] rev_left;
      logic [13:0] fwd_left;
   } duty_set_type;

   string duty_field_name [4] = '{"fwd_left", "rev_left", "fwd_right", "rev_right"};

   logic [15:0]        gain_prop, gain_integ, gain_deriv, ref_mv;
   logic signed [15:0] err_prev [MOTORS];
   logic signed [15:0] err_older [MOTORS];
   logic signed [14:0] accum [MOTORS];
   duty_set_type       duty_queue [$];

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // One motor of one tick: update the PID history, return the signed duty.
   function automatic longint advance_motor(int m, longint setp, longint count,
                                            longint supply);
      longint e, e1, e2, kp, ki, kd, vref, sum, corr, acc, ff, total;
      kp   = gain_prop;
      ki   = gain_integ;
      kd   = gain_deriv;
      vref = ref_mv;
      e    = setp - count;
      e1   = err_prev[m];
      e2   = err_older[m];
      sum  = kp * (e - e1) + ki * e + kd * (e - 2 * e1 + e2);
      corr = clamp(sum / 256, -32768, 32767);
      acc  = clamp(accum[m] + corr, -DUTY_LIMIT, DUTY_LIMIT);
      accum[m]     = acc[14:0];
      err_older[m] = err_prev[m];
      err_prev[m]  = e[15:0];
      // piecewise-linear feed-forward with its knee at 1000
      if (setp < 1000)
         ff = (setp * 1000) / 65;
      else
         ff = 1000 + (setp - 65) * 10;
      total = ff + acc;
      if (supply == 0)
         return (total > 0) ? DUTY_LIMIT : ((total < 0) ? -DUTY_LIMIT : 0);
      return clamp((total * vref) / supply, -DUTY_LIMIT, DUTY_LIMIT);
   endfunction

   function automatic duty_set_type predict_duties(logic [REQ_DATA_W-1:0] data, logic run);
      logic signed [11:0] tl, tr, cl, cr;
      longint             supply, dl, dr;
      duty_set_type       res;
      tl     = data[11:0];
      tr     = data[23:12];
      cl     = data[35:24];
      cr     = data[47:36];
      supply = data[61:48];
      dl     = advance_motor(0, run ? tl : 12'sd0, cl, supply);
      dr     = advance_motor(1, run ? tr : 12'sd0, cr, supply);
      res    = '0;
      if (dl >= 0) res.fwd_left  = 14'(dl); else res.rev_left  = 14'(-dl);
      if (dr >= 0) res.fwd_right = 14'(dr); else res.rev_right = 14'(-dr);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      duty_set_type              want;
      logic [RSP_DATA_W-1:0]     want_bits;
      logic [15:0]               reg_value;
      if (reset) begin
         gain_prop      = PROP_RESET;
         gain_integ     = INTEG_RESET;
         gain_deriv     = DERIV_RESET;
         ref_mv         = VREF_RESET;
         err_prev       = '{default: '0};
         err_older      = '{default: '0};
         accum          = '{default: '0};
         duty_queue.delete();
         mismatch_count = 0;
         outstanding   <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            case (csr_index_type'(csr_paddr[3:2]))
               CSR_PROP:  reg_value = gain_prop;
               CSR_INTEG: reg_value = gain_integ;
               CSR_DERIV: reg_value = gain_deriv;
               default:   reg_value = ref_mv;
            endcase
            if (csr_pwrite) begin
               case (csr_index_type'(csr_paddr[3:2]))
                  CSR_PROP:  gain_prop  = csr_pwdata[15:0];
                  CSR_INTEG: gain_integ = csr_pwdata[15:0];
                  CSR_DERIV: gain_deriv = csr_pwdata[15:0];
                  default:   ref_mv     = csr_pwdata[15:0];
               endcase
            end else if (csr_prdata !== {16'h0, reg_value}) begin
               report_mismatch($sformatf("register read at 0x%0h: expected %0d, got %0d",
                                         csr_paddr, reg_value, csr_prdata));
            end
         end
         if (req_tvalid && req_tready)
            duty_queue.push_back(predict_duties(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (duty_queue.size() == 0) begin
               report_mismatch($sformatf("response 0x%0h with no request pending", rsp_tdata));
            end else begin
               want      = duty_queue.pop_front();
               want_bits = want;
               for (int f = 0; f < 4; f++) begin
                  if (rsp_tdata[14*f +: 14] !== want_bits[14*f +: 14])
                     report_mismatch($sformatf("%s: expected %0d, got %0d",
                                               duty_field_name[f], want_bits[14*f +: 14],
                                               rsp_tdata[14*f +: 14]));
               end
            end
         end
         outstanding <= duty_queue.size();
      end
   end

endmodule

// File: tb/dual_motor_incremental_pid_drive_core_test.sv
`timescale 1ns / 1ps

module dual_motor_incremental_pid_drive_core_test;
   import dmpid_pkg::*;

   logic                    clock;
   logic                    reset;
   // target_left[11:0], target_right[23:12], count_left[35:24],
   // count_right[47:36], supply_mv[61:48], zero pad [63:62]
   logic [REQ_DATA_W-1:0]   req_tdata;
   // run_enable
   logic                    req_tuser;
   logic                    req_tvalid;
   wire                     req_tready;
   // fwd_left[13:0], rev_left[27:14], fwd_right[41:28], rev_right[55:42]
   wire [RSP_DATA_W-1:0]    rsp_tdata;
   wire                     rsp_tvalid;
   logic                    rsp_tready;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   wire [CSR_DATA_W-1:0]    csr_prdata;
   wire                     csr_pready;

   int                      mismatch_count;
   int                      outstanding;
   int                      sent_count;
   int                      stall_left;
   bit                      quiet;      // no idling on either side
   bit                      hold_rsp;   // long receiver hold-off in progress
   logic signed [11:0]      cruise_left, cruise_right;

   localparam int PHASES     = 8;
   localparam int PHASE_REQS = 130;
   localparam int HOLD_CYCLES = 400;

   dual_motor_incremental_pid_drive_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The checker snoops all three ports, predicts every response and
   // compares; this module only generates stimulus and calls the verdict.
   drive_duty_checker duty_check (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit: the slowest legal run is well under a fifth of this.
   initial begin
      #3_000_000;
      $display("dual_motor_incremental_pid_drive_core verification failed");
      $finish;
   end

   // Receiver: take responses, with random stall bursts and one long
   // hold-off. Exactly one assignment to rsp_tready per clock edge.
   initial begin
      rsp_tready <= 1'b0;
      stall_left  = 0;
      forever begin
         @(posedge clock);
         if (reset || hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 16);
         end
      end
   end

   // Long hold-off in the middle of a phase: the sender keeps offering, so
   // the block fills up and must stall its request side.
   initial begin
      hold_rsp <= 1'b0;
      wait (sent_count >= 460);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Offer one request and hold it until accepted; then maybe idle a burst.
   task automatic send_request(logic signed [11:0] tl, tr, cl, cr, logic run,
                               logic [13:0] supply);
      req_tdata  <= {2'b00, supply, cr, cl, tr, tl};
      req_tuser  <= run;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted response has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_access(csr_index_type idx, logic write, logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      // Upper data bits are junk; only the low 16 bits belong to the register.
      csr_pwdata  <= {16'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write all four registers with the block idle, then read them back.
   task automatic apply_settings(logic [15:0] kp, ki, kd, vref);
      drain();
      csr_access(CSR_PROP,  1'b1, kp);
      csr_access(CSR_INTEG, 1'b1, ki);
      csr_access(CSR_DERIV, 1'b1, kd);
      csr_access(CSR_VREF,  1'b1, vref);
      csr_access(CSR_PROP,  1'b0, '0);
      csr_access(CSR_INTEG, 1'b0, '0);
      csr_access(CSR_DERIV, 1'b0, '0);
      csr_access(CSR_VREF,  1'b0, '0);
   endtask

   // Encoder count close to the target, as when the loop is tracking.
   function automatic logic signed [11:0] near_count(logic signed [11:0] t);
      int v, ofs;
      ofs = $urandom_range(0, 40);
      v   = int'(t) + ofs - 20;
      if (v > 2047)  v = 2047;
      if (v < -2048) v = -2048;
      return 12'(v);
   endfunction

   // Field extremes and both sides of the feed-forward knee.
   function automatic logic signed [11:0] corner_speed();
      case ($urandom_range(0, 6))
         0:       return -12'sd2048;
         1:       return 12'sd2047;
         2:       return 12'sd0;
         3:       return 12'sd999;
         4:       return 12'sd1000;
         5:       return -12'sd1;
         default: return 12'($urandom());
      endcase
   endfunction

   task automatic random_request();
      int                 roll;
      logic signed [11:0] tl, tr, cl, cr;
      logic               run;
      logic [13:0]        supply;
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
         // Tracking: slowly moving targets with counts that follow them.
         if ($urandom_range(0, 15) == 0) cruise_left  = 12'($urandom());
         if ($urandom_range(0, 15) == 0) cruise_right = 12'($urandom());
         tl     = cruise_left;
         tr     = cruise_right;
         cl     = near_count(tl);
         cr     = near_count(tr);
         run    = ($urandom_range(0, 19) != 0);
         supply = 14'($urandom_range(9000, 16383));
      end else if (roll < 9) begin
         tl     = 12'($urandom());
         tr     = 12'($urandom());
         cl     = 12'($urandom());
         cr     = 12'($urandom());
         run    = 1'($urandom());
         supply = 14'($urandom());
      end else begin
         tl  = corner_speed();
         tr  = corner_speed();
         cl  = corner_speed();
         cr  = corner_speed();
         run = 1'($urandom());
         case ($urandom_range(0, 3))
            0:       supply = 14'd0;
            1:       supply = 14'd1;
            2:       supply = 14'd16383;
            default: supply = 14'($urandom());
         endcase
      end
      send_request(tl, tr, cl, cr, run, supply);
   endtask

   initial begin
      reset        <= 1'b1;
      req_tdata    <= '0;
      req_tuser    <= 1'b0;
      req_tvalid   <= 1'b0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      quiet        <= 1'b0;
      sent_count    = 0;
      cruise_left   = 12'sd300;
      cruise_right  = -12'sd300;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at reset gains. The first one hits zero supply with
      // a zero sum while the accumulators are still clear.
      send_request(12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b1, 14'd0);
      // zero supply: positive sum left, negative sum right
      send_request(12'sd500, -12'sd500, 12'sd0, 12'sd0, 1'b1, 14'd0);
      send_request(12'sd2047, -12'sd2048, 12'sd2047, -12'sd2048, 1'b1, 14'd16383);
      send_request(-12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048, 1'b1, 14'd1);
      // run flag clear drops both targets
      send_request(12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048, 1'b0, 14'd12600);
      // feed-forward knee from both sides
      send_request(12'sd999, 12'sd1000, 12'sd999, 12'sd1000, 1'b1, 14'd12600);
      send_request(12'sd1000, 12'sd999, 12'sd0, 12'sd0, 1'b1, 14'd8000);
      send_request(12'sd65, -12'sd65, 12'sd65, -12'sd65, 1'b1, 14'd16383);
      send_request(-12'sd1, 12'sd1, 12'sd0, 12'sd0, 1'b1, 14'd12600);
      send_request(12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0, 14'd16383);
      send_request(12'sd1234, -12'sd1234, 12'sd1200, -12'sd1300, 1'b1, 14'd11000);
      send_request(-12'sd2048, -12'sd2048, -12'sd2048, -12'sd2048, 1'b1, 14'd0);
      send_request(12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047, 1'b1, 14'd0);

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: ; // keep reset values
            1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: apply_settings(16'h0, 16'h0, 16'h0, 16'h0);   // zero reference too
            3: apply_settings(16'd256, 16'd128, 16'd64, 16'd12600);
            4: apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'd1);
            7: begin
               apply_settings(PROP_RESET, INTEG_RESET, DERIV_RESET, VREF_RESET);
               quiet <= 1'b1;
            end
            default: apply_settings(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 1024)),
                                    16'($urandom()), 16'($urandom_range(1, 65535)));
         endcase
         repeat (PHASE_REQS) random_request();
      end

      // Let the last responses drain, then give the block time to show any
      // stray response.
      drain();
      repeat (100) @(posedge clock);
      $display("Sent %0d requests over %0d register settings (extreme gains, zero reference,",
               sent_count, PHASES);
      $display("zero and full supply, %0d-cycle response hold-off, idle-free tail).",
               HOLD_CYCLES);
      if (mismatch_count == 0 && outstanding == 0)
         $display("dual_motor_incremental_pid_drive_core verification clean");
      else
         $display("dual_motor_incremental_pid_drive_core verification failed");
      $finish;
   end

endmodule
